// File: sv/bresenham_line_pixel_writer_assert.svh
// Assertion macros shared by the line writer modules.
`ifndef BRESENHAM_LINE_PIXEL_WRITER_ASSERT_SVH
`define BRESENHAM_LINE_PIXEL_WRITER_ASSERT_SVH

// Same-cycle implication, masked while reset is held.
`define BPW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpw: %m check failed");

// Next-cycle implication, masked while reset is held.
`define BPW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpw: %m check failed");

`endif

// File: sv/bpw_pkg.sv
// Types, constants and helpers for the Bresenham line pixel writer.
`timescale 1ns / 1ps
`default_nettype none
package bpw_pkg;

    localparam int FIELD_W      = 16;   // coordinate and size field width
    localparam int COLOUR_W     = 8;
    localparam int ADDR_W       = 34;
    localparam int PITCH_W      = 18;   // row pitch in bytes, padded to four
    localparam int X3_W         = 18;   // three bytes per pixel times x
    localparam int CFG_IDX_W    = 8;
    localparam int COORD_BITS_D = 16;
    localparam int QUEUE_DEPTH  = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // Input actions
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam logic [FIELD_W-1:0] WIDTH_RESET  = FIELD_W'(640);
    localparam logic [FIELD_W-1:0] HEIGHT_RESET = FIELD_W'(480);

    // One pixel on its way from the walker to the address stage
    typedef struct packed {
        logic [FIELD_W-1:0]  x;
        logic [FIELD_W-1:0]  y;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
        logic                last;
    } t_pix;

    // Row pitch: 3*w bytes rounded up to a multiple of four
    function automatic logic [PITCH_W-1:0] pitch_of(input logic [FIELD_W-1:0] w);
        logic [PITCH_W-1:0] t;
        t = PITCH_W'({w, 1'b0}) + PITCH_W'(w) + PITCH_W'(3);
        return {t[PITCH_W-1:2], 2'b00};
    endfunction

    localparam logic [PITCH_W-1:0] PITCH_RESET = pitch_of(WIDTH_RESET);

endpackage
`default_nettype wire

// File: sv/bpw_front.sv
// Front end: takes words, keeps the Bresenham walk state and emits pixels.
`timescale 1ns / 1ps
`default_nettype none
`include "bresenham_line_pixel_writer_assert.svh"
module bpw_front
    import bpw_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_D
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic                i_action,
    input  wire logic [FIELD_W-1:0]  i_start_x,
    input  wire logic [FIELD_W-1:0]  i_start_y,
    input  wire logic [FIELD_W-1:0]  i_end_x,
    input  wire logic [FIELD_W-1:0]  i_end_y,
    input  wire logic [COLOUR_W-1:0] i_red,
    input  wire logic [COLOUR_W-1:0] i_green,
    input  wire logic [COLOUR_W-1:0] i_blue,
    input  wire logic                i_q_full,
    output logic                     o_push,
    output t_pix                     o_pix
);

    localparam int C  = COORD_BITS;
    localparam int DW = COORD_BITS + 1;   // signed deltas
    localparam int EW = COORD_BITS + 3;   // error term
    localparam int E2 = COORD_BITS + 4;   // doubled error term

    logic [C-1:0]          r_x, r_y, r_tx, r_ty;
    logic signed [DW-1:0]  r_dx, r_ndy;
    logic signed [EW-1:0]  r_err, r_sum;
    logic                  r_sxn, r_syn;
    logic [COLOUR_W-1:0]   r_red, r_green, r_blue;
    logic                  r_active;

    logic [C-1:0]          n_x, n_y, n_tx, n_ty;
    logic signed [DW-1:0]  n_dx, n_ndy;
    logic signed [EW-1:0]  n_err, n_sum;
    logic                  n_sxn, n_syn, n_active;

    logic                  acc, start, last;
    logic [C-1:0]          x0, y0, x1, y1, dxm, dym;
    logic signed [E2-1:0]  e2;
    logic                  mv_x, mv_y;

    assign o_stall = i_q_full;
    assign acc     = i_valid && !i_q_full;
    assign start   = (i_action == ACT_START);

    assign x0 = i_start_x[C-1:0];
    assign y0 = i_start_y[C-1:0];
    assign x1 = i_end_x[C-1:0];
    assign y1 = i_end_y[C-1:0];
    assign dxm = (x1 >= x0) ? x1 - x0 : x0 - x1;
    assign dym = (y1 >= y0) ? y1 - y0 : y0 - y1;

    // Step decision from the doubled error term
    assign e2   = $signed({r_err, 1'b0});
    assign mv_x = (e2 >= E2'(r_ndy));
    assign mv_y = (e2 <= E2'(r_dx));

    // Next walk state
    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_tx  = r_tx;
        n_ty  = r_ty;
        n_dx  = r_dx;
        n_ndy = r_ndy;
        n_sxn = r_sxn;
        n_syn = r_syn;
        n_err = r_err;
        n_sum = r_sum;
        if (start) begin
            n_x   = x0;
            n_y   = y0;
            n_tx  = x1;
            n_ty  = y1;
            n_dx  = $signed({1'b0, dxm});
            n_ndy = -$signed({1'b0, dym});
            n_sxn = !(x0 < x1);
            n_syn = !(y0 < y1);
            n_sum = EW'(n_dx) + EW'(n_ndy);
            n_err = n_sum;
        end else begin
            if (mv_x) begin
                n_x = r_sxn ? r_x - C'(1) : r_x + C'(1);
            end
            if (mv_y) begin
                n_y = r_syn ? r_y - C'(1) : r_y + C'(1);
            end
            priority if (mv_x && mv_y) begin
                n_err = r_err + r_sum;
            end else if (mv_x) begin
                n_err = r_err + EW'(r_ndy);
            end else if (mv_y) begin
                n_err = r_err + EW'(r_dx);
            end
        end
    end

    assign last     = (n_x == n_tx) && (n_y == n_ty);
    assign o_push   = acc && (start || r_active);
    assign n_active = start ? !last : (r_active && !last);

    // Pixel word for the queue
    always_comb begin
        o_pix.x     = FIELD_W'(n_x);
        o_pix.y     = FIELD_W'(n_y);
        o_pix.red   = start ? i_red : r_red;
        o_pix.green = start ? i_green : r_green;
        o_pix.blue  = start ? i_blue : r_blue;
        o_pix.last  = last;
    end

    // Walk state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_tx     <= '0;
            r_ty     <= '0;
            r_dx     <= '0;
            r_ndy    <= '0;
            r_sxn    <= 1'b0;
            r_syn    <= 1'b0;
            r_err    <= '0;
            r_sum    <= '0;
            r_red    <= '0;
            r_green  <= '0;
            r_blue   <= '0;
        end else if (o_push) begin
            r_active <= n_active;
            r_x      <= n_x;
            r_y      <= n_y;
            r_tx     <= n_tx;
            r_ty     <= n_ty;
            r_dx     <= n_dx;
            r_ndy    <= n_ndy;
            r_sxn    <= n_sxn;
            r_syn    <= n_syn;
            r_err    <= n_err;
            r_sum    <= n_sum;
            if (start) begin
                r_red   <= i_red;
                r_green <= i_green;
                r_blue  <= i_blue;
            end
        end
    end

    // An active line never rests on its final endpoint
    `BPW_ASSERT_NOW(a_active_off_target, i_clk, i_rst_n, r_active, (r_x != r_tx) || (r_y != r_ty))
    // The final pixel ends the line
    `BPW_ASSERT_NEXT(a_last_ends_line, i_clk, i_rst_n, o_push && last, !r_active)
    // A start between distinct endpoints leaves a line running
    `BPW_ASSERT_NEXT(a_start_opens_line, i_clk, i_rst_n, acc && start && ((x0 != x1) || (y0 != y1)), r_active)

endmodule
`default_nettype wire

// File: sv/bpw_queue.sv
// Short pixel queue between the walker and the address stage.
`timescale 1ns / 1ps
`default_nettype none
`include "bresenham_line_pixel_writer_assert.svh"
module bpw_queue
    import bpw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_pix i_pix,
    input  wire logic i_pop,
    output logic      o_valid,
    output logic      o_full,
    output t_pix      o_pix
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_pix            r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            push, pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;
    assign o_pix   = r_mem[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_pix;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `BPW_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(DEPTH))
    `BPW_ASSERT_NEXT(a_drain_empty, i_clk, i_rst_n, pop && !push && (r_cnt == CW'(1)), !o_valid)
    `BPW_ASSERT_NEXT(a_fill_grows, i_clk, i_rst_n, push && !pop, r_cnt == $past(r_cnt) + CW'(1))

endmodule
`default_nettype wire

// File: sv/bpw_back.sv
// Back end: frame geometry registers and the two-stage byte address pipe.
`timescale 1ns / 1ps
`default_nettype none
module bpw_back
    import bpw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [FIELD_W-1:0]   i_cfg_data,
    input  wire logic                 i_q_valid,
    input  wire t_pix                 i_pix,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [ADDR_W-1:0]         o_byte_address,
    output logic                      o_in_bounds,
    output logic [FIELD_W-1:0]        o_pixel_x,
    output logic [FIELD_W-1:0]        o_pixel_y,
    output logic [COLOUR_W-1:0]       o_out_red,
    output logic [COLOUR_W-1:0]       o_out_green,
    output logic [COLOUR_W-1:0]       o_out_blue,
    output logic                      o_last
);

    logic [FIELD_W-1:0] r_width, r_height;
    logic [PITCH_W-1:0] r_pitch;

    logic               r_s1_valid, r_s1_in;
    logic [ADDR_W-1:0]  r_s1_prod;
    logic [X3_W-1:0]    r_s1_x3;
    t_pix               r_s1_pix;
    logic               r_s2_valid;

    logic               en1, en2, inb;
    logic [FIELD_W-1:0] row;
    logic [ADDR_W-1:0]  prod;
    logic [X3_W-1:0]    x3;

    // Geometry registers; pitch follows the width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_pitch  <= PITCH_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_IMAGE_WIDTH) begin
                r_width <= i_cfg_data;
                r_pitch <= pitch_of(i_cfg_data);
            end
            if (i_cfg_index == REG_IMAGE_HEIGHT) begin
                r_height <= i_cfg_data;
            end
        end
    end

    // Stage enables: each stage moves when the one after it has room
    assign en2   = !r_s2_valid || !i_stall;
    assign en1   = !r_s1_valid || en2;
    assign o_pop = i_q_valid && en1;

    // Stage one: bounds, flipped row, the row product and the column byte offset
    assign inb  = (i_pix.x < r_width) && (i_pix.y < r_height);
    assign row  = r_height - FIELD_W'(1) - i_pix.y;
    assign prod = r_pitch * row;
    assign x3   = X3_W'({i_pix.x, 1'b0}) + X3_W'(i_pix.x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_in   <= inb;
            r_s1_prod <= prod;
            r_s1_x3   <= x3;
            r_s1_pix  <= i_pix;
        end
    end

    // Stage two: column offset added, result word held for the sink
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_s1_valid) begin
            o_byte_address <= r_s1_in ? r_s1_prod + ADDR_W'(r_s1_x3) : '0;
            o_in_bounds    <= r_s1_in;
            o_pixel_x      <= r_s1_pix.x;
            o_pixel_y      <= r_s1_pix.y;
            o_out_red      <= r_s1_pix.red;
            o_out_green    <= r_s1_pix.green;
            o_out_blue     <= r_s1_pix.blue;
            o_last         <= r_s1_pix.last;
        end
    end

    assign o_valid = r_s2_valid;

endmodule
`default_nettype wire

// File: sv/bresenham_line_pixel_writer.sv
// Top level of the Bresenham line pixel writer.
`timescale 1ns / 1ps
`default_nettype none
// One input word per clock while o_stall is low, one pixel word per clock
// while i_stall is low. A start word loads the endpoints and colour and
// yields the first pixel; each step word yields the next pixel, the final
// endpoint carrying o_last; a step with no line running yields nothing.
// The walker updates its error term with a single add per word; the address
// stage registers the 18x16 pitch-by-row product, then adds the column offset.
// A four-word queue sits between walker and address stage, so input stays
// open while the output is held off, until it fills.
// Geometry registers: 0 image width, 1 image height (reset 640 x 480); write
// them only while no pixel is in flight. Out-of-image pixels are delivered
// with o_in_bounds low and a zero address.
module bresenham_line_pixel_writer
    import bpw_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_D
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [FIELD_W-1:0]   i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_action,
    input  wire logic [FIELD_W-1:0]   i_start_x,
    input  wire logic [FIELD_W-1:0]   i_start_y,
    input  wire logic [FIELD_W-1:0]   i_end_x,
    input  wire logic [FIELD_W-1:0]   i_end_y,
    input  wire logic [COLOUR_W-1:0]  i_red,
    input  wire logic [COLOUR_W-1:0]  i_green,
    input  wire logic [COLOUR_W-1:0]  i_blue,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [ADDR_W-1:0]         o_byte_address,
    output logic                      o_in_bounds,
    output logic [FIELD_W-1:0]        o_pixel_x,
    output logic [FIELD_W-1:0]        o_pixel_y,
    output logic [COLOUR_W-1:0]       o_out_red,
    output logic [COLOUR_W-1:0]       o_out_green,
    output logic [COLOUR_W-1:0]       o_out_blue,
    output logic                      o_last
);

    logic q_full, q_valid, push, pop;
    t_pix push_pix, pop_pix;

    // Walker
    bpw_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_action  (i_action),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_red     (i_red),
        .i_green   (i_green),
        .i_blue    (i_blue),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_pix     (push_pix)
    );

    // Decoupling queue
    bpw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pix   (push_pix),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_pix   (pop_pix)
    );

    // Address stage
    bpw_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (q_valid),
        .i_pix          (pop_pix),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_byte_address (o_byte_address),
        .o_in_bounds    (o_in_bounds),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire
